// File: design/rti_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the reflectivity table interpolator.
// Used by the divider and the top level; depends on nothing.
package rti_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_BINS = 1024;

  // Divider operand widths: the interpolation numerator is the widest dividend,
  // the angle step the widest divisor.
  localparam int DIV_N_W = 38;
  localparam int DIV_D_W = 24;

  localparam logic [16:0] REFL_ONE = 17'd65536;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q_FIRST,
    ST_Q_LAST,
    ST_Q_SCAN,
    ST_LK_START,
    ST_LK_DIV,
    ST_LK_RD,
    ST_LK_DATA,
    ST_MUL,
    ST_IP_START,
    ST_IP_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [10:0] count;
    logic [23:0] step;
    logic [31:0] start;
    logic [19:0] energy;
  } row_rec_t;

  localparam int ROW_REC_W = $bits(row_rec_t);

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

endpackage

// File: design/rti_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the row table and the bin table.
module rti_ram #(
  parameter int WIDTH = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rti_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rti_pkg; shared by the angle binning and the energy interpolation.
module rti_div (
  input  logic                      clk,
  input  logic                      rst,
  input  rti_pkg::div_req_t         req,
  output logic                      busy,
  output logic                      done,
  output logic [rti_pkg::DIV_N_W-1:0] quotient
);
  import rti_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W:0]   shifted;
  logic               ge;
  logic [DIV_D_W:0]   rem_next;

  always_comb begin
    shifted  = {rem[DIV_D_W-1:0], quotient[DIV_N_W-1]};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? shifted - {1'b0, dvs} : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        quotient <= req.dividend;
        rem      <= '0;
        dvs      <= req.divisor;
        cnt      <= CNT_W'(DIV_N_W);
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= {quotient[DIV_N_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/reflectivity_table_interpolator_core.sv
`timescale 1ns / 1ps
// Reflectivity table interpolator: row table and bin table RAMs with a sequencer.
// Define, write and unused beats go straight from acceptance to the done state, which loads the result
// register once the output is free; no beat is accepted until the result of the one before has loaded.
// A query scans up to MAX_ROWS-1 rows one per cycle, then does at most one angle lookup around a 38-step
// serial divide, or two and a further divide to interpolate when its energy falls between two rows.
// Reset clears control state and rows_in_use only; table contents stay undefined until written.
module reflectivity_table_interpolator_core #(
  parameter int MAX_ROWS = rti_pkg::DEF_MAX_ROWS,
  parameter int MAX_BINS = rti_pkg::DEF_MAX_BINS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row[7:0], bin[17:8], energy[37:18], angle[69:38], angle_step[93:70],
  // bin_count[104:94], value[122:105], zero fill above.
  input  logic [127:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reflectivity[16:0], zero fill above.
  output logic [23:0]  m_axis_tdata,
  // status[0]
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata
);
  import rti_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int BADR_W = ROW_W + BIN_W;

  // Input fields.
  op_t          in_op;
  logic [7:0]   in_row;
  logic [9:0]   in_bin;
  logic [19:0]  in_energy;
  logic [31:0]  in_angle;
  logic [23:0]  in_step;
  logic [10:0]  in_count;
  logic [17:0]  in_value;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_row    = s_axis_tdata[7:0];
  assign in_bin    = s_axis_tdata[17:8];
  assign in_energy = s_axis_tdata[37:18];
  assign in_angle  = s_axis_tdata[69:38];
  assign in_step   = s_axis_tdata[93:70];
  assign in_count  = s_axis_tdata[104:94];
  assign in_value  = s_axis_tdata[122:105];

  state_t state, state_next;

  logic [8:0]       rows_in_use;
  logic [19:0]      q_energy;
  logic [31:0]      q_angle;
  logic [ROW_W-1:0] n_last;
  logic [ROW_W-1:0] scan_i;
  row_rec_t         prev_rec, lo_rec, hi_rec;
  logic [ROW_W-1:0] prev_row, lo_row, hi_row;
  logic             pair;
  logic             lk_hi;
  logic [16:0]      r0, r1;
  logic [36:0]      p0, p1;
  logic [16:0]      res_refl;
  logic             res_status;

  // Memory ports.
  logic              row_we;
  logic [ROW_W-1:0]  row_waddr, row_raddr;
  row_rec_t          row_wdata, row_rdata;
  logic              bin_we;
  logic [BADR_W-1:0] bin_waddr, bin_raddr;
  logic [16:0]       bin_wdata, bin_rdata;

  div_req_t           div_req;
  logic               div_busy, div_done;
  logic [DIV_N_W-1:0] div_quo;

  logic        accept;
  logic [31:0] row_ext, bin_ext, n32;
  logic        row_ok, bin_ok;
  row_rec_t    cur_rec;
  logic [ROW_W-1:0] cur_row;
  logic [31:0] cnt_eff, bin_lim, bin_idx;
  logic [19:0] de_hi, de_lo, de_span;

  rti_ram #(.WIDTH(ROW_REC_W), .ADDR_W(ROW_W)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  rti_ram #(.WIDTH(17), .ADDR_W(BADR_W)) u_bin_ram (
    .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
    .raddr(bin_raddr), .rdata(bin_rdata)
  );

  rti_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .busy(div_busy), .done(div_done),
    .quotient(div_quo)
  );

  // Shared combinational helpers.
  always_comb begin
    accept  = s_axis_tvalid && s_axis_tready;
    row_ext = 32'(in_row);
    bin_ext = 32'(in_bin);
    row_ok  = row_ext < 32'(MAX_ROWS);
    bin_ok  = bin_ext < 32'(MAX_BINS);
    n32     = (32'(rows_in_use) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_in_use);
    cur_rec = lk_hi ? hi_rec : lo_rec;
    cur_row = lk_hi ? hi_row : lo_row;
    if (cur_rec.count == 11'd0) begin
      cnt_eff = 32'd1;
    end else if (32'(cur_rec.count) > 32'(MAX_BINS)) begin
      cnt_eff = 32'(MAX_BINS);
    end else begin
      cnt_eff = 32'(cur_rec.count);
    end
    bin_lim = cnt_eff - 32'd1;
    bin_idx = (div_quo > DIV_N_W'(bin_lim)) ? bin_lim : div_quo[31:0];
    de_hi   = hi_rec.energy - q_energy;
    de_lo   = q_energy - lo_rec.energy;
    de_span = hi_rec.energy - lo_rec.energy;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_QUERY && n32 != 32'd0) begin
            state_next = ST_Q_FIRST;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_Q_FIRST: begin
        state_next = (q_energy <= row_rdata.energy) ? ST_LK_START : ST_Q_LAST;
      end
      ST_Q_LAST: begin
        state_next = (row_rdata.energy < q_energy) ? ST_DONE : ST_Q_SCAN;
      end
      ST_Q_SCAN: begin
        if (row_rdata.energy >= q_energy) begin
          state_next = ST_LK_START;
        end
      end
      ST_LK_START: state_next = ST_LK_DIV;
      ST_LK_DIV:   state_next = div_done ? ST_LK_RD : ST_LK_DIV;
      ST_LK_RD:    state_next = ST_LK_DATA;
      ST_LK_DATA: begin
        if (!lk_hi) begin
          state_next = ST_LK_START;
        end else begin
          state_next = pair ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:      state_next = ST_IP_START;
      ST_IP_START: state_next = ST_IP_DIV;
      ST_IP_DIV:   state_next = div_done ? ST_DONE : ST_IP_DIV;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready, RAM ports and divider requests.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    row_we    = accept && in_op == OP_DEFINE && row_ok;
    row_waddr = row_ext[ROW_W-1:0];
    row_wdata = '{count: in_count, step: in_step, start: in_angle, energy: in_energy};
    bin_we    = accept && in_op == OP_WRITE && row_ok && bin_ok;
    bin_waddr = {row_ext[ROW_W-1:0], bin_ext[BIN_W-1:0]};
    if (in_value[17]) begin
      bin_wdata = '0;
    end else if (in_value[16:0] > REFL_ONE) begin
      bin_wdata = REFL_ONE;
    end else begin
      bin_wdata = in_value[16:0];
    end
    bin_raddr = {cur_row, bin_idx[BIN_W-1:0]};
    div_req   = '{start: 1'b0, dividend: '0, divisor: '0};
    row_raddr = '0;
    unique case (state)
      ST_Q_FIRST: row_raddr = n_last;
      ST_Q_LAST:  row_raddr = ROW_W'(1);
      ST_Q_SCAN:  row_raddr = scan_i + 1'b1;
      ST_LK_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = (q_angle >= cur_rec.start) ?
                           DIV_N_W'(q_angle - cur_rec.start) : '0;
        div_req.divisor  = (cur_rec.step == '0) ? DIV_D_W'(1) : cur_rec.step;
      end
      ST_IP_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(p0) + DIV_N_W'(p1);
        div_req.divisor  = DIV_D_W'(de_span);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rows_in_use   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        rows_in_use <= cfg_wdata;
      end
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q_energy   <= in_energy;
        q_angle    <= in_angle;
        n_last     <= ROW_W'(n32 - 32'd1);
        res_refl   <= '0;
        res_status <= (in_op == OP_QUERY && n32 == 32'd0);
      end
      ST_Q_FIRST: begin
        hi_rec   <= row_rdata;
        hi_row   <= '0;
        prev_rec <= row_rdata;
        prev_row <= '0;
        pair     <= 1'b0;
        lk_hi    <= 1'b1;
      end
      ST_Q_LAST: begin
        scan_i <= ROW_W'(1);
      end
      ST_Q_SCAN: begin
        // Row data here belongs to scan_i; the next row is already being read.
        if (row_rdata.energy == q_energy) begin
          hi_rec <= row_rdata;
          hi_row <= scan_i;
          pair   <= 1'b0;
          lk_hi  <= 1'b1;
        end else if (row_rdata.energy > q_energy) begin
          lo_rec <= prev_rec;
          lo_row <= prev_row;
          hi_rec <= row_rdata;
          hi_row <= scan_i;
          pair   <= 1'b1;
          lk_hi  <= 1'b0;
        end else begin
          prev_rec <= row_rdata;
          prev_row <= scan_i;
          scan_i   <= scan_i + 1'b1;
        end
      end
      ST_LK_DATA: begin
        if (lk_hi) begin
          r1       <= bin_rdata;
          res_refl <= bin_rdata;
        end else begin
          r0    <= bin_rdata;
          lk_hi <= 1'b1;
        end
      end
      ST_MUL: begin
        p0 <= 37'(r0) * 37'(de_hi);
        p1 <= 37'(r1) * 37'(de_lo);
      end
      ST_IP_DIV: begin
        if (div_done) begin
          res_refl <= div_quo[16:0];
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {7'd0, res_refl};
          m_axis_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_QUERY) |=> state == ST_DONE)
    else $error("define or write beat did not go straight to result");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == 24'd0)
    else $error("empty-table status with nonzero reflectivity");
`endif

endmodule
